### rtl/narp_pkg.sv
// Shared types and constants for the note arpeggiator.
`timescale 1ns / 1ps
`default_nettype none

package narp_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;

   // Pattern codes
   localparam logic [1:0] PAT_UP     = 2'd0;
   localparam logic [1:0] PAT_DOWN   = 2'd1;
   localparam logic [1:0] PAT_BOUNCE = 2'd2;
   localparam logic [1:0] PAT_RANDOM = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_PATTERN      = 2'd0;
   localparam logic [1:0] CSR_OCTAVE_SPAN  = 2'd1;
   localparam logic [1:0] CSR_REPEAT_COUNT = 2'd2;

   localparam int SEMITONES_PER_OCTAVE = 12;
   localparam int NOTE_MAX             = 127;
   localparam int ENTRY_W              = 18;

   typedef struct packed {
      logic [3:0] chan;
      logic [6:0] pitch;
      logic [6:0] vel;
   } narp_entry_type;

   typedef enum logic [1:0] {
      RD_PREV = 2'd0,
      RD_CUR  = 2'd1,
      RD_NEXT = 2'd2
   } narp_rd_sel_type;

   typedef struct packed {
      logic            latch_req;
      logic            idx_load_count;
      logic            idx_clear;
      logic            idx_inc;
      logic            idx_dec;
      narp_rd_sel_type held_rd_sel;
      logic            held_wr_new;
      logic            held_wr_moved;
      logic            count_inc;
      logic            count_dec;
      logic            snap_wr;
      logic            walk_init;
      logic            walk_clamp;
      logic            rsp_emit;
   } narp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       held_full;
      logic       held_empty;
      logic       idx_zero;
      logic       idx_at_end;
      logic       idx_last;
      logic       pitch_gt;
      logic       pitch_eq;
      logic       need_restart;
   } narp_status_type;

endpackage

`default_nettype wire

### rtl/note_arpeggiator.sv
// Note arpeggiator: sorted held-note list with an up/down/bounce step walk;
// the random pattern code walks up. An item is accepted when start is high
// while busy is low, and busy stays high until the item is done. A note-on
// is dropped when the list is full; it is written straight into an empty
// list, and otherwise each held entry above its pitch moves up one slot to
// make room first. A note-off visits every held entry, match or miss: it
// scans up to the match and shifts each entry after it down one slot. A
// step tick plays nothing with nothing held; one that starts a new pass
// first copies the held list to the snapshot. Each entry move or copy takes
// a read state and a write state because the list memories have one
// registered read port. The played note appears on the rsp_ ports with
// rsp_valid for exactly one cycle, the cycle in which busy drops; it must
// be taken then, as the receiver cannot stall. csr_ready is always high;
// write the registers only while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module note_arpeggiator #(
   parameter int MAX_NOTES   = 16,
   parameter int MAX_OCTAVES = 4,
   parameter int MAX_REPEATS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [3:0] req_channel,
   input  wire logic [6:0] req_note_number,
   input  wire logic [6:0] req_velocity,
   output logic            rsp_valid,
   output logic [3:0]      rsp_out_channel,
   output logic [6:0]      rsp_out_note,
   output logic [6:0]      rsp_out_velocity,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [2:0] csr_data
);

   narp_pkg::narp_cmd_type    cmd;
   narp_pkg::narp_status_type status;

   assign csr_ready = 1'b1;

   narp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   narp_datapath #(
      .MAX_NOTES   (MAX_NOTES),
      .MAX_OCTAVES (MAX_OCTAVES),
      .MAX_REPEATS (MAX_REPEATS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_channel      (req_channel),
      .req_note_number  (req_note_number),
      .req_velocity     (req_velocity),
      .csr_wr           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_velocity (rsp_out_velocity)
   );

endmodule

`default_nettype wire

### rtl/narp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module narp_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/narp_ctrl.sv
// Controller state machine for the note arpeggiator.
`timescale 1ns / 1ps
`default_nettype none

module narp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire narp_pkg::narp_status_type status,
   output narp_pkg::narp_cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_DISPATCH = 12'b0000_0000_0010,
      S_INS_RD   = 12'b0000_0000_0100,
      S_INS_CMP  = 12'b0000_0000_1000,
      S_DEL_RD   = 12'b0000_0001_0000,
      S_DEL_CMP  = 12'b0000_0010_0000,
      S_SH_RD    = 12'b0000_0100_0000,
      S_SH_WR    = 12'b0000_1000_0000,
      S_CP_RD    = 12'b0001_0000_0000,
      S_CP_WR    = 12'b0010_0000_0000,
      S_WK_RD    = 12'b0100_0000_0000,
      S_WK_OUT   = 12'b1000_0000_0000
   } narp_state_type;

   narp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.held_rd_sel = narp_pkg::RD_CUR;
      state_in        = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.func)
               narp_pkg::FUNC_NOTE_ON: begin
                  if (status.held_full) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_load_count = 1'b1;
                     state_in           = S_INS_RD;
                  end
               end
               narp_pkg::FUNC_NOTE_OFF: begin
                  cmd.idx_clear = 1'b1;
                  state_in      = S_DEL_RD;
               end
               narp_pkg::FUNC_TICK: begin
                  if (status.held_empty) begin
                     state_in = S_IDLE;
                  end else if (status.need_restart) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_CP_RD;
                  end else begin
                     state_in = S_WK_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INS_RD: begin
            if (status.idx_zero) begin
               cmd.held_wr_new = 1'b1;
               cmd.count_inc   = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.held_rd_sel = narp_pkg::RD_PREV;
               state_in        = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // entry below is higher: move it up one slot and keep looking
            if (status.pitch_gt) begin
               cmd.held_wr_moved = 1'b1;
               cmd.idx_dec       = 1'b1;
               state_in          = S_INS_RD;
            end else begin
               cmd.held_wr_new = 1'b1;
               cmd.count_inc   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DEL_RD: begin
            if (status.idx_at_end) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_DEL_CMP;
            end
         end
         S_DEL_CMP: begin
            if (status.pitch_eq) begin
               state_in = S_SH_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DEL_RD;
            end
         end
         S_SH_RD: begin
            if (status.idx_last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.held_rd_sel = narp_pkg::RD_NEXT;
               state_in        = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.held_wr_moved = 1'b1;
            cmd.idx_inc       = 1'b1;
            state_in          = S_SH_RD;
         end
         S_CP_RD: begin
            if (status.idx_at_end) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WK_RD;
            end else begin
               state_in = S_CP_WR;
            end
         end
         S_CP_WR: begin
            cmd.snap_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_CP_RD;
         end
         S_WK_RD: begin
            cmd.walk_clamp = 1'b1;
            state_in       = S_WK_OUT;
         end
         S_WK_OUT: begin
            cmd.rsp_emit = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a snapshot write always uses the data read in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CP_WR) |-> $past(state_ff == S_CP_RD))
      else $error("snapshot write without preceding read");

endmodule

`default_nettype wire

### rtl/narp_datapath.sv
// Datapath: held and snapshot lists, walk counters, config registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module narp_datapath #(
   parameter int MAX_NOTES   = 16,
   parameter int MAX_OCTAVES = 4,
   parameter int MAX_REPEATS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire narp_pkg::narp_cmd_type cmd,
   output narp_pkg::narp_status_type   status,
   input  wire logic [1:0]             req_func,
   input  wire logic [3:0]             req_channel,
   input  wire logic [6:0]             req_note_number,
   input  wire logic [6:0]             req_velocity,
   input  wire logic                   csr_wr,
   input  wire logic [1:0]             csr_index,
   input  wire logic [2:0]             csr_data,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_out_channel,
   output logic [6:0]                  rsp_out_note,
   output logic [6:0]                  rsp_out_velocity
);

   localparam int NW    = $clog2(MAX_NOTES);
   localparam int CW    = $clog2(MAX_NOTES + 1);
   localparam int OW    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int RW    = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1;
   localparam int OLW   = $clog2(MAX_OCTAVES + 1);
   localparam int RLW   = $clog2(MAX_REPEATS + 1);
   localparam int SUM_W = 8 + OW;

   // config
   logic [1:0] pattern_ff;
   logic [2:0] octave_span_ff;
   logic [2:0] repeat_count_ff;

   // latched request
   logic [1:0] func_ff;
   narp_pkg::narp_entry_type req_entry_ff;

   logic [CW-1:0] idx_ff;
   logic [CW-1:0] held_count_ff;
   logic [CW-1:0] snap_count_ff;
   logic [NW-1:0] walk_idx_ff;
   logic [OW-1:0] walk_oct_ff;
   logic [RW-1:0] walk_rep_ff;
   logic          walk_desc_ff;
   logic          restart_ff;

   logic          rsp_valid_ff;
   logic [3:0]    rsp_chan_ff;
   logic [6:0]    rsp_note_ff;
   logic [6:0]    rsp_vel_ff;

   logic [CW-1:0] idx_prev, idx_next, held_rd_idx;
   localparam int ENTRY_W_L = narp_pkg::ENTRY_W;
   logic [ENTRY_W_L-1:0] held_rdata_raw, snap_rdata_raw, held_wdata;
   narp_pkg::narp_entry_type held_rdata, snap_rdata;

   logic [OLW-1:0] o_lim;
   logic [RLW-1:0] r_lim;
   logic [OW-1:0]  o_max;
   logic [RW-1:0]  r_max;
   logic [NW-1:0]  n_max;
   logic [NW-1:0]  idx_c;
   logic [OW-1:0]  oct_c;
   logic [RW-1:0]  rep_c;

   logic [NW-1:0]  up_idx, dn_idx, nxt_idx;
   logic [OW-1:0]  up_oct, dn_oct, nxt_oct;
   logic [RW-1:0]  up_rep, dn_rep, nxt_rep;
   logic           nxt_desc, nxt_restart;
   logic           at_first, at_last;
   logic [SUM_W-1:0] pitch_sum;

   // ---------------- config registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff      <= narp_pkg::PAT_UP;
         octave_span_ff  <= 3'd1;
         repeat_count_ff <= 3'd1;
      end else if (csr_wr) begin
         unique case (csr_index)
            narp_pkg::CSR_PATTERN:      pattern_ff      <= csr_data[1:0];
            narp_pkg::CSR_OCTAVE_SPAN:  octave_span_ff  <= csr_data;
            narp_pkg::CSR_REPEAT_COUNT: repeat_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // saturated limits
   assign o_lim = (octave_span_ff == 3'd0) ? OLW'(1) :
                  (32'(octave_span_ff) > MAX_OCTAVES) ? OLW'(MAX_OCTAVES) :
                  OLW'(octave_span_ff);
   assign r_lim = (repeat_count_ff == 3'd0) ? RLW'(1) :
                  (32'(repeat_count_ff) > MAX_REPEATS) ? RLW'(MAX_REPEATS) :
                  RLW'(repeat_count_ff);
   assign o_max = OW'(o_lim - 1'b1);
   assign r_max = RW'(r_lim - 1'b1);
   assign n_max = NW'(snap_count_ff - 1'b1);

   // ---------------- request latch ----------------
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff            <= req_func;
         req_entry_ff.chan  <= req_channel;
         req_entry_ff.pitch <= req_note_number;
         req_entry_ff.vel   <= req_velocity;
      end
   end

   // ---------------- scan index and held count ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_load_count) begin
         idx_ff <= held_count_ff;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else if (cmd.count_inc) begin
         held_count_ff <= held_count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         held_count_ff <= held_count_ff - 1'b1;
      end
   end

   assign idx_prev = idx_ff - 1'b1;
   assign idx_next = idx_ff + 1'b1;

   always_comb begin
      unique case (cmd.held_rd_sel)
         narp_pkg::RD_PREV: held_rd_idx = idx_prev;
         narp_pkg::RD_NEXT: held_rd_idx = idx_next;
         default:           held_rd_idx = idx_ff;
      endcase
   end

   assign held_wdata = cmd.held_wr_new ? req_entry_ff : held_rdata_raw;
   assign held_rdata = held_rdata_raw;
   assign snap_rdata = snap_rdata_raw;

   narp_ram #(
      .WIDTH (ENTRY_W_L),
      .DEPTH (MAX_NOTES)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (cmd.held_wr_new | cmd.held_wr_moved),
      .wr_addr (idx_ff[NW-1:0]),
      .wr_data (held_wdata),
      .rd_addr (held_rd_idx[NW-1:0]),
      .rd_data (held_rdata_raw)
   );

   narp_ram #(
      .WIDTH (ENTRY_W_L),
      .DEPTH (MAX_NOTES)
   ) u_snap_ram (
      .clock   (clock),
      .wr_en   (cmd.snap_wr),
      .wr_addr (idx_ff[NW-1:0]),
      .wr_data (held_rdata_raw),
      .rd_addr (idx_c),
      .rd_data (snap_rdata_raw)
   );

   // ---------------- status ----------------
   assign status.func         = func_ff;
   assign status.held_full    = (held_count_ff == CW'(MAX_NOTES));
   assign status.held_empty   = (held_count_ff == '0);
   assign status.idx_zero     = (idx_ff == '0);
   assign status.idx_at_end   = (idx_ff >= held_count_ff);
   assign status.idx_last     = ({1'b0, idx_ff} + 1'b1 >= {1'b0, held_count_ff});
   assign status.pitch_gt     = (held_rdata.pitch > req_entry_ff.pitch);
   assign status.pitch_eq     = (held_rdata.pitch == req_entry_ff.pitch);
   assign status.need_restart = restart_ff || (snap_count_ff == '0);

   // ---------------- walk ----------------
   // pull counters back inside the limits in force at this tick
   assign idx_c = (walk_idx_ff > n_max) ? n_max : walk_idx_ff;
   assign oct_c = (walk_oct_ff > o_max) ? o_max : walk_oct_ff;
   assign rep_c = (walk_rep_ff > r_max) ? r_max : walk_rep_ff;

   assign at_first = (walk_idx_ff == '0) && (walk_oct_ff == '0) && (walk_rep_ff == '0);
   assign at_last  = (walk_idx_ff == n_max) && (walk_oct_ff == o_max) &&
                     (walk_rep_ff == r_max);

   always_comb begin
      up_idx = walk_idx_ff;
      up_oct = walk_oct_ff;
      up_rep = walk_rep_ff;
      if (walk_rep_ff != r_max) begin
         up_rep = walk_rep_ff + 1'b1;
      end else begin
         up_rep = '0;
         if (walk_idx_ff != n_max) begin
            up_idx = walk_idx_ff + 1'b1;
         end else begin
            up_idx = '0;
            up_oct = (walk_oct_ff != o_max) ? walk_oct_ff + 1'b1 : '0;
         end
      end
   end

   always_comb begin
      dn_idx = walk_idx_ff;
      dn_oct = walk_oct_ff;
      dn_rep = walk_rep_ff;
      if (walk_rep_ff != '0) begin
         dn_rep = walk_rep_ff - 1'b1;
      end else begin
         dn_rep = r_max;
         if (walk_idx_ff != '0) begin
            dn_idx = walk_idx_ff - 1'b1;
         end else begin
            dn_idx = n_max;
            if (walk_oct_ff != '0) begin
               dn_oct = walk_oct_ff - 1'b1;
            end
         end
      end
   end

   always_comb begin
      nxt_idx     = walk_idx_ff;
      nxt_oct     = walk_oct_ff;
      nxt_rep     = walk_rep_ff;
      nxt_desc    = walk_desc_ff;
      nxt_restart = restart_ff;
      if (pattern_ff == narp_pkg::PAT_UP || pattern_ff == narp_pkg::PAT_RANDOM) begin
         if (at_last) begin
            nxt_restart = 1'b1;
         end else begin
            nxt_idx = up_idx;
            nxt_oct = up_oct;
            nxt_rep = up_rep;
         end
      end else if (pattern_ff == narp_pkg::PAT_BOUNCE && !walk_desc_ff) begin
         if (at_last) begin
            // single-position sequence restarts instead of turning around
            if (at_first) begin
               nxt_restart = 1'b1;
            end else begin
               nxt_desc = 1'b1;
               nxt_idx  = dn_idx;
               nxt_oct  = dn_oct;
               nxt_rep  = dn_rep;
            end
         end else begin
            nxt_idx = up_idx;
            nxt_oct = up_oct;
            nxt_rep = up_rep;
         end
      end else begin
         if (at_first) begin
            nxt_restart = 1'b1;
         end else begin
            nxt_idx = dn_idx;
            nxt_oct = dn_oct;
            nxt_rep = dn_rep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_count_ff <= '0;
         walk_idx_ff   <= '0;
         walk_oct_ff   <= '0;
         walk_rep_ff   <= '0;
         walk_desc_ff  <= 1'b0;
         restart_ff    <= 1'b0;
      end else if (cmd.walk_init) begin
         snap_count_ff <= held_count_ff;
         restart_ff    <= 1'b0;
         if (pattern_ff == narp_pkg::PAT_DOWN) begin
            walk_idx_ff  <= NW'(held_count_ff - 1'b1);
            walk_oct_ff  <= o_max;
            walk_rep_ff  <= r_max;
            walk_desc_ff <= 1'b1;
         end else begin
            walk_idx_ff  <= '0;
            walk_oct_ff  <= '0;
            walk_rep_ff  <= '0;
            walk_desc_ff <= 1'b0;
         end
      end else if (cmd.walk_clamp) begin
         walk_idx_ff <= idx_c;
         walk_oct_ff <= oct_c;
         walk_rep_ff <= rep_c;
      end else if (cmd.rsp_emit) begin
         walk_idx_ff  <= nxt_idx;
         walk_oct_ff  <= nxt_oct;
         walk_rep_ff  <= nxt_rep;
         walk_desc_ff <= nxt_desc;
         restart_ff   <= nxt_restart;
      end else if (cmd.count_inc && held_count_ff == '0) begin
         restart_ff <= 1'b1;
      end
   end

   // ---------------- result ----------------
   assign pitch_sum = SUM_W'(snap_rdata.pitch) +
                      SUM_W'(walk_oct_ff) * SUM_W'(narp_pkg::SEMITONES_PER_OCTAVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_emit) begin
         rsp_chan_ff <= snap_rdata.chan;
         rsp_vel_ff  <= snap_rdata.vel;
         rsp_note_ff <= (pitch_sum > SUM_W'(narp_pkg::NOTE_MAX)) ?
                        7'(narp_pkg::NOTE_MAX) : pitch_sum[6:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_out_note     = rsp_note_ff;
   assign rsp_out_velocity = rsp_vel_ff;

   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CW'(MAX_NOTES))
      else $error("held count beyond list depth");

   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (held_count_ff == $past(held_count_ff) ||
                         held_count_ff == $past(held_count_ff) + 1'b1 ||
                         held_count_ff == $past(held_count_ff) - 1'b1))
      else $error("held count moved by more than one");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_emit |-> (snap_count_ff != '0) && (walk_idx_ff <= n_max))
      else $error("walk read outside snapshot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(rsp_valid_ff))
      else $error("back-to-back result strobes");

endmodule

`default_nettype wire
